// ----- design/wasc_pkg.sv -----
`default_nettype none
package wasc_pkg;

    localparam int ALARM_COUNT_DEF = 4;
    localparam int ALARM_MAX       = 4;

    localparam int IDX_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int WORD_W     = 24;
    localparam int TIME_W     = 32;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int WDAY_W     = 3;
    localparam int VOL_W      = 5;
    localparam int DAYS_W     = 7;
    localparam int SNZ_W      = 6;
    localparam int DAY_CNT_W  = 3;
    localparam int BEST_W     = 14;
    localparam int DIST_W     = 16;
    localparam int MOD_W      = 11;
    localparam int MINUTE_NO_W = 27;

    localparam logic [CFG_ADDR_W-1:0] REG_SNOOZE_EN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SNOOZE_MIN = 3'd5;

    localparam logic [WORD_W-1:0] ALARM_RESET_WORD = 24'd30727;
    localparam logic [SNZ_W-1:0]  SNOOZE_MIN_RESET = 6'd5;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_STOP   = 2'd1;
    localparam logic [1:0] ACT_SNOOZE = 2'd2;

    // floor(x / 60) = (x * RECIP) >> RECIP_SHIFT for every 32 bit x
    localparam logic [TIME_W-1:0] MIN_RECIP   = 32'h8888_8889;
    localparam int                RECIP_SHIFT = 37;

    localparam logic [MOD_W-1:0]  SEC_PER_MIN = 11'd60;
    localparam logic [BEST_W-1:0] MIN_PER_DAY = 14'd1440;
    localparam logic [DAY_CNT_W-1:0] LAST_DAY = 3'd7;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] unix_time;
        logic [HOUR_W-1:0] hour_now;
        logic [MIN_W-1:0]  minute_now;
        logic [WDAY_W-1:0] weekday_now;
    } t_item;

    typedef struct packed {
        logic              ringing;
        logic              snoozed;
        logic              active_valid;
        logic [IDX_W-1:0]  active_index;
        logic              fired;
        logic [VOL_W-1:0]  play_volume;
        logic              next_valid;
        logic [IDX_W-1:0]  next_index;
        logic [HOUR_W-1:0] next_hour;
        logic [MIN_W-1:0]  next_minute;
        logic [DAY_CNT_W-1:0] next_days_ahead;
        logic [BEST_W-1:0] next_minutes_until;
    } t_result;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              snooze_en;
        logic [SNZ_W-1:0]  snooze_min;
    } t_cfg_view;

    function automatic logic [HOUR_W-1:0] f_hour(input logic [WORD_W-1:0] w);
        return w[4:0];
    endfunction

    function automatic logic [MIN_W-1:0] f_minute(input logic [WORD_W-1:0] w);
        return w[10:5];
    endfunction

    function automatic logic [VOL_W-1:0] f_volume(input logic [WORD_W-1:0] w);
        return w[15:11];
    endfunction

    function automatic logic [DAYS_W-1:0] f_days(input logic [WORD_W-1:0] w);
        return w[22:16];
    endfunction

    function automatic logic f_enable(input logic [WORD_W-1:0] w);
        return w[23];
    endfunction

    // minutes of day from raw hour and minute
    function automatic logic [MOD_W-1:0] f_day_min(input logic [HOUR_W-1:0] h,
                                                   input logic [MIN_W-1:0] m);
        return MOD_W'({6'd0, h} * SEC_PER_MIN) + MOD_W'(m);
    endfunction

    // sum of weekday and days ahead, at most fourteen, modulo seven
    function automatic logic [2:0] f_mod7(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (r >= 4'd14) begin
            r = r - 4'd14;
        end else if (r >= 4'd7) begin
            r = r - 4'd7;
        end
        return r[2:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/wasc_regs.sv -----
`default_nettype none
module wasc_regs
    import wasc_pkg::*;
#(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [WORD_W-1:0]     i_cfg_data,
    input  wire logic [IDX_W-1:0]      i_rd_addr,
    output t_cfg_view                  o_view
);

    localparam int IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

    logic [WORD_W-1:0] r_word [ALARM_COUNT];
    logic              r_snooze_en;
    logic [SNZ_W-1:0]  r_snooze_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_word[i] <= ALARM_RESET_WORD;
            end
            r_snooze_en  <= 1'b1;
            r_snooze_min <= SNOOZE_MIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr < CFG_ADDR_W'(ALARM_COUNT)) begin
                r_word[i_cfg_addr[IW-1:0]] <= i_cfg_data;
            end else if (i_cfg_addr == REG_SNOOZE_EN) begin
                r_snooze_en <= i_cfg_data[0];
            end else if (i_cfg_addr == REG_SNOOZE_MIN) begin
                r_snooze_min <= i_cfg_data[SNZ_W-1:0];
            end
        end
    end

    assign o_view.word       = r_word[i_rd_addr[IW-1:0]];
    assign o_view.snooze_en  = r_snooze_en;
    assign o_view.snooze_min = r_snooze_min;

endmodule
`default_nettype wire

// ----- design/wasc_engine.sv -----
`default_nettype none
module wasc_engine
    import wasc_pkg::*;
#(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    input  wire t_item            i_item,
    output logic                  o_item_ready,
    input  wire t_cfg_view        i_view,
    output logic [IDX_W-1:0]      o_rd_addr,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ready
);

    localparam int IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACT  = 6'b000010,
        S_FIRE = 6'b000100,
        S_SCAN = 6'b001000,
        S_VOL  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_ring, n_ring;
    logic                   r_snooze, n_snooze;
    logic                   r_held_valid, n_held_valid;
    logic [IDX_W-1:0]       r_held_idx, n_held_idx;
    logic [TIME_W-1:0]      r_snooze_end, n_snooze_end;
    logic [MINUTE_NO_W-1:0] r_last [ALARM_COUNT];
    logic                   n_last_we;

    t_item                  r_item, n_item;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [DAY_CNT_W-1:0]   r_day, n_day;
    logic [MINUTE_NO_W-1:0] r_minute_no, n_minute_no;
    logic                   r_fired, n_fired;
    logic [VOL_W-1:0]       r_vol, n_vol;
    logic                   r_nvalid, n_nvalid;
    logic [IDX_W-1:0]       r_nidx, n_nidx;
    logic [HOUR_W-1:0]      r_nhour, n_nhour;
    logic [MIN_W-1:0]       r_nmin, n_nmin;
    logic [DAY_CNT_W-1:0]   r_ndays, n_ndays;
    logic [BEST_W-1:0]      r_best, n_best;

    logic [2*TIME_W-1:0]    w_prod;
    logic [TIME_W-1:0]      w_snz_len;
    logic [WORD_W-1:0]      w_word;
    logic [DAYS_W:0]        w_days8;
    logic [2:0]             w_wday;
    logic [MOD_W-1:0]       w_am;
    logic [MOD_W-1:0]       w_cur;
    logic [BEST_W-1:0]      w_day_off;
    logic signed [DIST_W-1:0] w_diff;
    logic                   w_diff_pos;
    logic                   w_hit;
    logic                   w_fire_match;
    logic                   w_alarm_live;

    assign w_prod    = {32'd0, r_item.unix_time} * {32'd0, MIN_RECIP};
    assign w_snz_len = TIME_W'({6'd0, i_view.snooze_min} * {1'b0, SEC_PER_MIN});
    assign w_word    = i_view.word;
    assign w_days8   = {1'b0, f_days(w_word)};
    assign w_wday    = f_mod7({1'b0, r_item.weekday_now} + {1'b0, r_day});
    assign w_am      = f_day_min(f_hour(w_word), f_minute(w_word));
    assign w_cur     = f_day_min(r_item.hour_now, r_item.minute_now);
    assign w_day_off = BEST_W'({11'd0, r_day} * MIN_PER_DAY);
    assign w_diff    = $signed({2'b00, w_day_off}) + $signed({5'd0, w_am})
                     - $signed({5'd0, w_cur});
    assign w_diff_pos   = !w_diff[DIST_W-1] && (w_diff != '0);
    assign w_hit        = w_days8[w_wday];
    assign w_alarm_live = f_enable(w_word) && (f_days(w_word) != '0);
    assign w_fire_match = f_enable(w_word)
                       && (f_hour(w_word) == r_item.hour_now)
                       && (f_minute(w_word) == r_item.minute_now)
                       && w_days8[r_item.weekday_now]
                       && (r_last[r_idx[IW-1:0]] != r_minute_no);

    assign o_rd_addr    = (r_state == S_VOL) ? r_held_idx : r_idx;
    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);

    always_comb begin
        n_state      = r_state;
        n_ring       = r_ring;
        n_snooze     = r_snooze;
        n_held_valid = r_held_valid;
        n_held_idx   = r_held_idx;
        n_snooze_end = r_snooze_end;
        n_last_we    = 1'b0;
        n_item       = r_item;
        n_idx        = r_idx;
        n_day        = r_day;
        n_minute_no  = r_minute_no;
        n_fired      = r_fired;
        n_vol        = r_vol;
        n_nvalid     = r_nvalid;
        n_nidx       = r_nidx;
        n_nhour      = r_nhour;
        n_nmin       = r_nmin;
        n_ndays      = r_ndays;
        n_best       = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_fired  = 1'b0;
                    n_nvalid = 1'b0;
                    n_nidx   = '0;
                    n_nhour  = '0;
                    n_nmin   = '0;
                    n_ndays  = '0;
                    n_best   = '1;
                    n_state  = S_ACT;
                end
            end
            S_ACT: begin
                n_minute_no = w_prod[RECIP_SHIFT +: MINUTE_NO_W];
                n_idx       = '0;
                n_day       = '0;
                n_state     = S_SCAN;
                case (r_item.action)
                    ACT_TICK: begin
                        if (!r_ring) begin
                            if (r_snooze) begin
                                if (r_item.unix_time >= r_snooze_end) begin
                                    n_snooze = 1'b0;
                                    if (r_held_valid) begin
                                        n_ring  = 1'b1;
                                        n_fired = 1'b1;
                                    end
                                end
                            end else begin
                                n_state = S_FIRE;
                            end
                        end
                    end
                    ACT_STOP: begin
                        n_ring       = 1'b0;
                        n_snooze     = 1'b0;
                        n_snooze_end = '0;
                        n_held_valid = 1'b0;
                        n_held_idx   = '0;
                    end
                    ACT_SNOOZE: begin
                        if (r_ring && i_view.snooze_en && r_held_valid) begin
                            n_ring       = 1'b0;
                            n_snooze     = 1'b1;
                            n_snooze_end = r_item.unix_time + w_snz_len;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FIRE: begin
                if (w_fire_match) begin
                    n_last_we    = 1'b1;
                    n_held_idx   = r_idx;
                    n_held_valid = 1'b1;
                    n_ring       = 1'b1;
                    n_fired      = 1'b1;
                    n_idx        = '0;
                    n_state      = S_SCAN;
                end else if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                if (w_alarm_live && w_hit && w_diff_pos
                        && (w_diff[BEST_W-1:0] < r_best)) begin
                    n_best   = w_diff[BEST_W-1:0];
                    n_nvalid = 1'b1;
                    n_nidx   = r_idx;
                    n_nhour  = f_hour(w_word);
                    n_nmin   = f_minute(w_word);
                    n_ndays  = r_day;
                end
                if (!w_alarm_live || (w_hit && w_diff_pos) || (r_day == LAST_DAY)) begin
                    n_day = '0;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_VOL;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_day = r_day + 1'b1;
                end
            end
            S_VOL: begin
                n_vol   = r_held_valid ? f_volume(w_word) : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ring       <= 1'b0;
            r_snooze     <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_idx   <= '0;
            r_snooze_end <= '0;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_last[i] <= '1;
            end
        end else begin
            r_state      <= n_state;
            r_ring       <= n_ring;
            r_snooze     <= n_snooze;
            r_held_valid <= n_held_valid;
            r_held_idx   <= n_held_idx;
            r_snooze_end <= n_snooze_end;
            if (n_last_we) begin
                r_last[r_idx[IW-1:0]] <= r_minute_no;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_day       <= n_day;
        r_minute_no <= n_minute_no;
        r_fired     <= n_fired;
        r_vol       <= n_vol;
        r_nvalid    <= n_nvalid;
        r_nidx      <= n_nidx;
        r_nhour     <= n_nhour;
        r_nmin      <= n_nmin;
        r_ndays     <= n_ndays;
        r_best      <= n_best;
    end

    always_comb begin
        o_res.ringing            = r_ring;
        o_res.snoozed            = r_snooze;
        o_res.active_valid       = r_held_valid;
        o_res.active_index       = r_held_valid ? r_held_idx : '0;
        o_res.fired              = r_fired;
        o_res.play_volume        = r_vol;
        o_res.next_valid         = r_nvalid;
        o_res.next_index         = r_nidx;
        o_res.next_hour          = r_nhour;
        o_res.next_minute        = r_nmin;
        o_res.next_days_ahead    = r_ndays;
        o_res.next_minutes_until = r_nvalid ? r_best : '0;
    end

endmodule
`default_nettype wire

// ----- design/weekday_alarm_scheduler_snooze.sv -----
// each item passes S_ACT, S_FIRE for a tick that looks for a match, the next-alarm scan
// S_SCAN of up to eight days per alarm, then S_VOL and S_DONE; a new item is taken only
// once the result of the last one has been handed to the output register
// the single compare unit steps over the alarms and days ahead one pair per cycle
// reset: synchronous active low, alarm words 07:00 disabled, snooze on for 5 minutes
`default_nettype none
module weekday_alarm_scheduler_snooze
    import wasc_pkg::*;
#(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // unix_time, hour_now, minute_now, weekday_now, zero pad
    input  wire logic [47:0]           s_axis_tdata,
    // action
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // ringing, snoozed, active_valid, active_index, fired, play_volume,
    // next_valid, next_index, next_hour, next_minute, next_days_ahead,
    // next_minutes_until, zero pad
    output logic [47:0]                m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [WORD_W-1:0]     i_cfg_data
);

    t_item            w_item;
    t_cfg_view        w_view;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_slot_free;

    logic             r_out_valid;
    t_result          r_out;

    assign w_item.action      = s_axis_tuser;
    assign w_item.unix_time   = s_axis_tdata[31:0];
    assign w_item.hour_now    = s_axis_tdata[36:32];
    assign w_item.minute_now  = s_axis_tdata[42:37];
    assign w_item.weekday_now = s_axis_tdata[45:43];

    wasc_regs #(
        .ALARM_COUNT(ALARM_COUNT)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_rd_addr  (w_rd_addr),
        .o_view     (w_view)
    );

    wasc_engine #(
        .ALARM_COUNT(ALARM_COUNT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .i_item       (w_item),
        .o_item_ready (s_axis_tready),
        .i_view       (w_view),
        .o_rd_addr    (w_rd_addr),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_slot_free)
    );

    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out.next_minutes_until,
                            r_out.next_days_ahead,
                            r_out.next_minute,
                            r_out.next_hour,
                            r_out.next_index,
                            r_out.next_valid,
                            r_out.play_volume,
                            r_out.fired,
                            r_out.active_index,
                            r_out.active_valid,
                            r_out.snoozed,
                            r_out.ringing};

endmodule
`default_nettype wire
